>>> src/gpa_pkg.sv
// Shared types, constants and the operation program of the pair acceleration unit.
// Every module of the block imports this package.
// It has no dependencies of its own.
package gpa_pkg;

  // Field widths.
  localparam int unsigned FpW     = 64;
  localparam int unsigned InDataW  = 448;
  localparam int unsigned OutDataW = 192;

  // Binary64 constants.
  localparam logic [63:0] ISQ_MAGIC = 64'h5fe6eb50c7b537a9;
  localparam logic [63:0] FP_HALF   = 64'h3fe0000000000000;
  localparam logic [63:0] FP_THALF  = 64'h3ff8000000000000;
  localparam logic [63:0] CANON_NAN = 64'h7ff8000000000000;

  // Functional unit codes.
  localparam logic [1:0] UNIT_ADD = 2'd0;
  localparam logic [1:0] UNIT_MUL = 2'd1;
  localparam logic [1:0] UNIT_ISQ = 2'd2;

  // Operand source codes.
  localparam logic [4:0] SRC_TX    = 5'd0;
  localparam logic [4:0] SRC_TY    = 5'd1;
  localparam logic [4:0] SRC_TZ    = 5'd2;
  localparam logic [4:0] SRC_SX    = 5'd3;
  localparam logic [4:0] SRC_SY    = 5'd4;
  localparam logic [4:0] SRC_SZ    = 5'd5;
  localparam logic [4:0] SRC_MASS  = 5'd6;
  localparam logic [4:0] SRC_DX    = 5'd7;
  localparam logic [4:0] SRC_DY    = 5'd8;
  localparam logic [4:0] SRC_DZ    = 5'd9;
  localparam logic [4:0] SRC_T0    = 5'd10;
  localparam logic [4:0] SRC_T1    = 5'd11;
  localparam logic [4:0] SRC_Y     = 5'd12;
  localparam logic [4:0] SRC_AX    = 5'd13;
  localparam logic [4:0] SRC_AY    = 5'd14;
  localparam logic [4:0] SRC_AZ    = 5'd15;
  localparam logic [4:0] SRC_HALF  = 5'd16;
  localparam logic [4:0] SRC_THALF = 5'd17;

  // Result destination codes.
  localparam logic [3:0] DST_DX = 4'd0;
  localparam logic [3:0] DST_DY = 4'd1;
  localparam logic [3:0] DST_DZ = 4'd2;
  localparam logic [3:0] DST_T0 = 4'd3;
  localparam logic [3:0] DST_T1 = 4'd4;
  localparam logic [3:0] DST_Y  = 4'd5;
  localparam logic [3:0] DST_AX = 4'd6;
  localparam logic [3:0] DST_AY = 4'd7;
  localparam logic [3:0] DST_AZ = 4'd8;

  // Program length.
  localparam int unsigned NumSteps = 23;
  localparam logic [4:0]  LAST_STEP = 5'(NumSteps - 1);

  // One program step: unit, negate flag, two sources and a destination.
  typedef struct packed {
    logic [1:0] unit;
    logic       neg;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic [3:0] dst;
  } prog_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load_in;
    logic  issue;
    prog_t op;
    logic  load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_done;
  } status_t;

  // Special-case flags that travel beside a floating-point operation.
  typedef struct packed {
    logic nan;
    logic inf;
    logic isgn;
  } spec_t;

  // The operation program. For an add, neg subtracts src_b; for a multiply
  // it inverts the sign of the product.
  function automatic prog_t prog_step(input logic [4:0] idx);
    prog_t p;
    p = '{UNIT_ADD, 1'b0, SRC_T0, SRC_T0, DST_T0};
    unique case (idx)
      5'd0:  p = '{UNIT_ADD, 1'b1, SRC_TX,    SRC_SX,   DST_DX};
      5'd1:  p = '{UNIT_ADD, 1'b1, SRC_TY,    SRC_SY,   DST_DY};
      5'd2:  p = '{UNIT_ADD, 1'b1, SRC_TZ,    SRC_SZ,   DST_DZ};
      5'd3:  p = '{UNIT_MUL, 1'b0, SRC_DX,    SRC_DX,   DST_T0};
      5'd4:  p = '{UNIT_MUL, 1'b0, SRC_DY,    SRC_DY,   DST_T1};
      5'd5:  p = '{UNIT_ADD, 1'b0, SRC_T0,    SRC_T1,   DST_T0};
      5'd6:  p = '{UNIT_MUL, 1'b0, SRC_DZ,    SRC_DZ,   DST_T1};
      5'd7:  p = '{UNIT_ADD, 1'b0, SRC_T0,    SRC_T1,   DST_T0};
      5'd8:  p = '{UNIT_ISQ, 1'b0, SRC_T0,    SRC_T0,   DST_Y};
      5'd9:  p = '{UNIT_MUL, 1'b0, SRC_T0,    SRC_HALF, DST_T0};
      5'd10: p = '{UNIT_MUL, 1'b0, SRC_T0,    SRC_Y,    DST_T0};
      5'd11: p = '{UNIT_MUL, 1'b0, SRC_T0,    SRC_Y,    DST_T0};
      5'd12: p = '{UNIT_ADD, 1'b1, SRC_THALF, SRC_T0,   DST_T0};
      5'd13: p = '{UNIT_MUL, 1'b0, SRC_Y,     SRC_T0,   DST_Y};
      5'd14: p = '{UNIT_MUL, 1'b0, SRC_Y,     SRC_Y,    DST_T0};
      5'd15: p = '{UNIT_MUL, 1'b0, SRC_T0,    SRC_Y,    DST_T0};
      5'd16: p = '{UNIT_MUL, 1'b1, SRC_MASS,  SRC_T0,   DST_T0};
      5'd17: p = '{UNIT_MUL, 1'b0, SRC_DX,    SRC_T0,   DST_T1};
      5'd18: p = '{UNIT_ADD, 1'b0, SRC_AX,    SRC_T1,   DST_AX};
      5'd19: p = '{UNIT_MUL, 1'b0, SRC_DY,    SRC_T0,   DST_T1};
      5'd20: p = '{UNIT_ADD, 1'b0, SRC_AY,    SRC_T1,   DST_AY};
      5'd21: p = '{UNIT_MUL, 1'b0, SRC_DZ,    SRC_T0,   DST_T1};
      5'd22: p = '{UNIT_ADD, 1'b0, SRC_AZ,    SRC_T1,   DST_AZ};
      default: p = '{UNIT_ADD, 1'b0, SRC_T0, SRC_T0, DST_T0};
    endcase
    return p;
  endfunction

endpackage

>>> src/gpa_fadd.sv
// Six-stage binary64 adder, round to nearest even, subnormals kept.
// Uses spec_t and constants from gpa_pkg.
// A NaN result always comes out as the canonical quiet NaN.
module gpa_fadd import gpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] result
);

  // Leading zero count of a 56-bit word; 56 when the word is zero.
  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic [5:0] v_r;

  // Stage 1: classify, order by magnitude, exponent difference.
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [63:0] big, lit;
  logic [10:0] eb_eff, el_eff;
  spec_t       sp1_nxt;

  logic        sg1_r, sub1_r;
  logic [10:0] ex1_r, d1_r;
  logic [52:0] mx1_r, my1_r;
  spec_t       sp1_r;

  always_comb begin
    a_nan  = (op_a[62:52] == 11'h7ff) && (op_a[51:0] != '0);
    b_nan  = (op_b[62:52] == 11'h7ff) && (op_b[51:0] != '0);
    a_inf  = (op_a[62:52] == 11'h7ff) && (op_a[51:0] == '0);
    b_inf  = (op_b[62:52] == 11'h7ff) && (op_b[51:0] == '0);
    swap   = op_b[62:0] > op_a[62:0];
    big    = swap ? op_b : op_a;
    lit    = swap ? op_a : op_b;
    eb_eff = (big[62:52] == '0) ? 11'd1 : big[62:52];
    el_eff = (lit[62:52] == '0) ? 11'd1 : lit[62:52];
    sp1_nxt.nan  = a_nan || b_nan || (a_inf && b_inf && (op_a[63] != op_b[63]));
    sp1_nxt.inf  = a_inf || b_inf;
    sp1_nxt.isgn = a_inf ? op_a[63] : op_b[63];
  end

  always_ff @(posedge clk) begin
    sg1_r  <= big[63];
    sub1_r <= big[63] ^ lit[63];
    ex1_r  <= eb_eff;
    d1_r   <= eb_eff - el_eff;
    mx1_r  <= {big[62:52] != '0, big[51:0]};
    my1_r  <= {lit[62:52] != '0, lit[51:0]};
    sp1_r  <= sp1_nxt;
  end

  // Stage 2: align the smaller operand, folding lost bits into a sticky bit.
  logic [5:0]   dcap;
  logic [119:0] al_wide;
  logic [55:0]  y_al;

  logic        sg2_r, sub2_r;
  logic [10:0] ex2_r;
  logic [55:0] x2_r, y2_r;
  spec_t       sp2_r;

  always_comb begin
    dcap    = (d1_r > 11'd63) ? 6'd63 : d1_r[5:0];
    al_wide = {my1_r, 3'b000, 64'd0} >> dcap;
    y_al    = {al_wide[119:65], al_wide[64] | (|al_wide[63:0])};
  end

  always_ff @(posedge clk) begin
    sg2_r  <= sg1_r;
    sub2_r <= sub1_r;
    ex2_r  <= ex1_r;
    x2_r   <= {mx1_r, 3'b000};
    y2_r   <= y_al;
    sp2_r  <= sp1_r;
  end

  // Stage 3: add or subtract the magnitudes.
  logic        sg3_r, sub3_r;
  logic [10:0] ex3_r;
  logic [56:0] sum3_r;
  spec_t       sp3_r;

  always_ff @(posedge clk) begin
    sg3_r  <= sg2_r;
    sub3_r <= sub2_r;
    ex3_r  <= ex2_r;
    sum3_r <= sub2_r ? ({1'b0, x2_r} - {1'b0, y2_r}) : ({1'b0, x2_r} + {1'b0, y2_r});
    sp3_r  <= sp2_r;
  end

  // Stage 4: leading zero count; an exact cancellation gives positive zero.
  logic        sg4_r;
  logic [10:0] ex4_r;
  logic [56:0] sum4_r;
  logic [5:0]  lz4_r;
  spec_t       sp4_r;

  always_ff @(posedge clk) begin
    sg4_r  <= (sum3_r == '0 && sub3_r) ? 1'b0 : sg3_r;
    ex4_r  <= ex3_r;
    sum4_r <= sum3_r;
    lz4_r  <= lzc56(sum3_r[55:0]);
    sp4_r  <= sp3_r;
  end

  // Stage 5: normalize, stopping at the subnormal boundary.
  logic [11:0] lim;
  logic [5:0]  sh;
  logic [55:0] nl;
  logic [55:0] n_nxt;
  logic [11:0] fe_nxt;

  logic        sg5_r;
  logic [55:0] n5_r;
  logic [11:0] fe5_r;
  spec_t       sp5_r;

  always_comb begin
    lim = {1'b0, ex4_r} - 12'd1;
    sh  = ({6'd0, lz4_r} < lim) ? lz4_r : lim[5:0];
    nl  = sum4_r[55:0] << sh;
    if (sum4_r[56]) begin
      n_nxt  = {sum4_r[56:2], sum4_r[1] | sum4_r[0]};
      fe_nxt = {1'b0, ex4_r} + 12'd1;
    end else begin
      n_nxt  = nl;
      fe_nxt = nl[55] ? ({1'b0, ex4_r} - {6'd0, sh}) : 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    sg5_r <= sg4_r;
    n5_r  <= n_nxt;
    fe5_r <= fe_nxt;
    sp5_r <= sp4_r;
  end

  // Stage 6: round to nearest even and pack.
  logic        up;
  logic [62:0] mag;
  logic [63:0] res_nxt;
  logic [63:0] result_r;

  always_comb begin
    up  = n5_r[2] & (n5_r[1] | n5_r[0] | n5_r[3]);
    mag = {fe5_r[10:0], n5_r[54:3]} + 63'(up);
    if (sp5_r.nan) begin
      res_nxt = CANON_NAN;
    end else if (sp5_r.inf) begin
      res_nxt = {sp5_r.isgn, 11'h7ff, 52'd0};
    end else if (fe5_r >= 12'd2047) begin
      res_nxt = {sg5_r, 11'h7ff, 52'd0};
    end else begin
      res_nxt = {sg5_r, mag};
    end
  end

  always_ff @(posedge clk) begin
    result_r <= res_nxt;
  end

  // Stage valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], start};
    end
  end

  assign done   = v_r[5];
  assign result = result_r;

endmodule

>>> src/gpa_fmul.sv
// Nine-stage binary64 multiplier, round to nearest even, subnormals kept.
// The 53x53 significand product is built from four partial products of up to 27x27 bits.
// Uses spec_t and constants from gpa_pkg.
module gpa_fmul import gpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] result
);

  // Leading zero count of a 106-bit word.
  function automatic logic [6:0] lzc106(input logic [105:0] v);
    logic [6:0] n;
    logic       found;
    n = 7'd106;
    found = 1'b0;
    for (int i = 105; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 7'(105 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic [8:0] v_r;

  // Stage 1: classify and unpack.
  logic  a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  spec_t sp_nxt;

  logic        sg1_r, zr1_r;
  logic [11:0] es1_r;
  logic [52:0] ma1_r, mb1_r;
  spec_t       sp1_r;

  always_comb begin
    a_nan  = (op_a[62:52] == 11'h7ff) && (op_a[51:0] != '0);
    b_nan  = (op_b[62:52] == 11'h7ff) && (op_b[51:0] != '0);
    a_inf  = (op_a[62:52] == 11'h7ff) && (op_a[51:0] == '0);
    b_inf  = (op_b[62:52] == 11'h7ff) && (op_b[51:0] == '0);
    a_zero = op_a[62:0] == '0;
    b_zero = op_b[62:0] == '0;
    sp_nxt.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    sp_nxt.inf  = a_inf || b_inf;
    sp_nxt.isgn = op_a[63] ^ op_b[63];
  end

  always_ff @(posedge clk) begin
    sg1_r <= op_a[63] ^ op_b[63];
    zr1_r <= a_zero || b_zero;
    es1_r <= 12'((op_a[62:52] == '0) ? 11'd1 : op_a[62:52])
           + 12'((op_b[62:52] == '0) ? 11'd1 : op_b[62:52]);
    ma1_r <= {op_a[62:52] != '0, op_a[51:0]};
    mb1_r <= {op_b[62:52] != '0, op_b[51:0]};
    sp1_r <= sp_nxt;
  end

  // Stages 2 to 5: accumulate one partial product per stage.
  logic        sg_r [2:5];
  logic        zr_r [2:5];
  logic [11:0] es_r [2:5];
  logic [52:0] ma_r [2:4];
  logic [52:0] mb_r [2:4];
  spec_t       sp_r [2:5];
  logic [105:0] acc_r [2:5];

  logic [53:0] pp2, pp3, pp4, pp5;

  always_comb begin
    pp2 = {27'd0, ma1_r[26:0]} * {27'd0, mb1_r[26:0]};
    pp3 = {28'd0, ma_r[2][52:27]} * {27'd0, mb_r[2][26:0]};
    pp4 = {27'd0, ma_r[3][26:0]} * {28'd0, mb_r[3][52:27]};
    pp5 = {28'd0, ma_r[4][52:27]} * {28'd0, mb_r[4][52:27]};
  end

  always_ff @(posedge clk) begin
    sg_r[2]  <= sg1_r;
    zr_r[2]  <= zr1_r;
    es_r[2]  <= es1_r;
    ma_r[2]  <= ma1_r;
    mb_r[2]  <= mb1_r;
    sp_r[2]  <= sp1_r;
    acc_r[2] <= 106'(pp2);

    sg_r[3]  <= sg_r[2];
    zr_r[3]  <= zr_r[2];
    es_r[3]  <= es_r[2];
    ma_r[3]  <= ma_r[2];
    mb_r[3]  <= mb_r[2];
    sp_r[3]  <= sp_r[2];
    acc_r[3] <= acc_r[2] + (106'(pp3) << 27);

    sg_r[4]  <= sg_r[3];
    zr_r[4]  <= zr_r[3];
    es_r[4]  <= es_r[3];
    ma_r[4]  <= ma_r[3];
    mb_r[4]  <= mb_r[3];
    sp_r[4]  <= sp_r[3];
    acc_r[4] <= acc_r[3] + (106'(pp4) << 27);

    sg_r[5]  <= sg_r[4];
    zr_r[5]  <= zr_r[4];
    es_r[5]  <= es_r[4];
    sp_r[5]  <= sp_r[4];
    acc_r[5] <= acc_r[4] + (106'(pp5) << 54);
  end

  // Stage 6: leading zero count and the result exponent.
  logic         sg6_r, zr6_r;
  logic [6:0]   lz6_r;
  logic [13:0]  ex6_r;
  logic [105:0] p6_r;
  spec_t        sp6_r;
  logic [6:0]   lz_nxt;

  assign lz_nxt = lzc106(acc_r[5]);

  always_ff @(posedge clk) begin
    sg6_r <= sg_r[5];
    zr6_r <= zr_r[5];
    lz6_r <= lz_nxt;
    ex6_r <= {2'b00, es_r[5]} - 14'd1022 - {7'd0, lz_nxt};
    p6_r  <= acc_r[5];
    sp6_r <= sp_r[5];
  end

  // Stage 7: normalize so the leading one sits at the top bit.
  logic         sg7_r, zr7_r;
  logic [13:0]  ex7_r;
  logic [105:0] n7_r;
  spec_t        sp7_r;

  always_ff @(posedge clk) begin
    sg7_r <= sg6_r;
    zr7_r <= zr6_r;
    ex7_r <= ex6_r;
    n7_r  <= p6_r << lz6_r;
    sp7_r <= sp6_r;
  end

  // Stage 8: shift into the subnormal range when the exponent is too small.
  logic         tiny;
  logic [13:0]  rdist;
  logic [6:0]   rsh;
  logic [233:0] rwide;

  logic         sg8_r, zr8_r, st8_r;
  logic [11:0]  fe8_r;
  logic [105:0] n8_r;
  spec_t        sp8_r;

  always_comb begin
    tiny  = $signed(ex7_r) < 14'sd1;
    rdist = 14'd1 - ex7_r;
    rsh   = !tiny ? 7'd0 : ((rdist > 14'd127) ? 7'd127 : rdist[6:0]);
    rwide = {n7_r, 128'd0} >> rsh;
  end

  always_ff @(posedge clk) begin
    sg8_r <= sg7_r;
    zr8_r <= zr7_r;
    st8_r <= |rwide[127:0];
    fe8_r <= tiny ? 12'd0 : ((ex7_r > 14'd2047) ? 12'd2047 : ex7_r[11:0]);
    n8_r  <= rwide[233:128];
    sp8_r <= sp7_r;
  end

  // Stage 9: round to nearest even and pack.
  logic        up;
  logic [62:0] mag;
  logic [63:0] res_nxt;
  logic [63:0] result_r;

  always_comb begin
    up  = n8_r[52] & ((|n8_r[51:0]) | st8_r | n8_r[53]);
    mag = {fe8_r[10:0], n8_r[104:53]} + 63'(up);
    if (sp8_r.nan) begin
      res_nxt = CANON_NAN;
    end else if (sp8_r.inf) begin
      res_nxt = {sp8_r.isgn, 11'h7ff, 52'd0};
    end else if (zr8_r) begin
      res_nxt = {sg8_r, 63'd0};
    end else if (fe8_r >= 12'd2047) begin
      res_nxt = {sg8_r, 11'h7ff, 52'd0};
    end else begin
      res_nxt = {sg8_r, mag};
    end
  end

  always_ff @(posedge clk) begin
    result_r <= res_nxt;
  end

  // Stage valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[7:0], start};
    end
  end

  assign done   = v_r[8];
  assign result = result_r;

endmodule

>>> src/gpa_datapath.sv
// Datapath: operand registers, accumulators, the shared adder and multiplier,
// the inverse square root first guess and the result register.
// Depends on gpa_pkg, gpa_fadd and gpa_fmul.
module gpa_datapath import gpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  output logic [OutDataW-1:0] out_data
);

  // Operand and working registers.
  logic [63:0] tx_r, ty_r, tz_r, sx_r, sy_r, sz_r, mass_r;
  logic [63:0] dx_r, dy_r, dz_r, t0_r, t1_r, y_r;
  logic [63:0] ax_r, ay_r, az_r;
  logic [63:0] out_x_r, out_y_r, out_z_r;

  // Pending destination of the operation in flight.
  logic [3:0]  dst_r;
  logic        neg_mul_r;
  logic        isq_done_r;
  logic [63:0] isq_res_r;

  // Operand selection.
  function automatic logic [63:0] pick(
    input logic [4:0] sel,
    input logic [63:0] tx, input logic [63:0] ty, input logic [63:0] tz,
    input logic [63:0] sx, input logic [63:0] sy, input logic [63:0] sz,
    input logic [63:0] ms, input logic [63:0] dx, input logic [63:0] dy,
    input logic [63:0] dz, input logic [63:0] t0, input logic [63:0] t1,
    input logic [63:0] yv, input logic [63:0] ax, input logic [63:0] ay,
    input logic [63:0] az);
    logic [63:0] v;
    v = '0;
    unique case (sel)
      SRC_TX:    v = tx;
      SRC_TY:    v = ty;
      SRC_TZ:    v = tz;
      SRC_SX:    v = sx;
      SRC_SY:    v = sy;
      SRC_SZ:    v = sz;
      SRC_MASS:  v = ms;
      SRC_DX:    v = dx;
      SRC_DY:    v = dy;
      SRC_DZ:    v = dz;
      SRC_T0:    v = t0;
      SRC_T1:    v = t1;
      SRC_Y:     v = yv;
      SRC_AX:    v = ax;
      SRC_AY:    v = ay;
      SRC_AZ:    v = az;
      SRC_HALF:  v = FP_HALF;
      SRC_THALF: v = FP_THALF;
      default:   v = '0;
    endcase
    return v;
  endfunction

  logic [63:0] opa, opb, add_b;
  logic        add_start, mul_start;
  logic        add_done, mul_done;
  logic [63:0] add_res, mul_res;

  always_comb begin
    opa = pick(cmd.op.src_a, tx_r, ty_r, tz_r, sx_r, sy_r, sz_r, mass_r, dx_r, dy_r,
               dz_r, t0_r, t1_r, y_r, ax_r, ay_r, az_r);
    opb = pick(cmd.op.src_b, tx_r, ty_r, tz_r, sx_r, sy_r, sz_r, mass_r, dx_r, dy_r,
               dz_r, t0_r, t1_r, y_r, ax_r, ay_r, az_r);
    add_b     = {opb[63] ^ cmd.op.neg, opb[62:0]};
    add_start = cmd.issue && (cmd.op.unit == UNIT_ADD);
    mul_start = cmd.issue && (cmd.op.unit == UNIT_MUL);
  end

  gpa_fadd u_fadd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (add_start),
    .op_a   (opa),
    .op_b   (add_b),
    .done   (add_done),
    .result (add_res)
  );

  gpa_fmul u_fmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (opa),
    .op_b   (opb),
    .done   (mul_done),
    .result (mul_res)
  );

  // First guess: magic constant minus the arithmetic half of the bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isq_done_r <= 1'b0;
    end else begin
      isq_done_r <= cmd.issue && (cmd.op.unit == UNIT_ISQ);
    end
  end

  always_ff @(posedge clk) begin
    isq_res_r <= ISQ_MAGIC - {opa[63], opa[63:1]};
    if (cmd.issue) begin
      dst_r     <= cmd.op.dst;
      neg_mul_r <= cmd.op.neg;
    end
  end

  // Write-back value of whichever unit finished.
  logic        wb_en;
  logic [63:0] wb_val;

  always_comb begin
    wb_en  = add_done || mul_done || isq_done_r;
    wb_val = isq_res_r;
    if (add_done) begin
      wb_val = add_res;
    end else if (mul_done) begin
      wb_val = {mul_res[63] ^ neg_mul_r, mul_res[62:0]};
    end
  end

  // Input capture, write-back of working values and result capture.
  // The accumulators are written in their own block below.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tx_r   <= in_tdata[63:0];
      ty_r   <= in_tdata[127:64];
      tz_r   <= in_tdata[191:128];
      sx_r   <= in_tdata[255:192];
      sy_r   <= in_tdata[319:256];
      sz_r   <= in_tdata[383:320];
      mass_r <= in_tdata[447:384];
    end
    if (wb_en) begin
      unique case (dst_r)
        DST_DX:  dx_r <= wb_val;
        DST_DY:  dy_r <= wb_val;
        DST_DZ:  dz_r <= wb_val;
        DST_T0:  t0_r <= wb_val;
        DST_T1:  t1_r <= wb_val;
        DST_Y:   y_r  <= wb_val;
        default: t1_r <= t1_r;
      endcase
    end
    if (cmd.load_out) begin
      out_x_r <= ax_r;
      out_y_r <= ay_r;
      out_z_r <= az_r;
    end
  end

  // Accumulators are state: reset and clear set them to positive zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      az_r <= '0;
    end else if (cmd.load_in && in_tuser) begin
      ax_r <= '0;
      ay_r <= '0;
      az_r <= '0;
    end else if (wb_en) begin
      if (dst_r == DST_AX) ax_r <= wb_val;
      if (dst_r == DST_AY) ay_r <= wb_val;
      if (dst_r == DST_AZ) az_r <= wb_val;
    end
  end

  assign status.op_done = wb_en;
  assign out_data       = {out_z_r, out_y_r, out_x_r};

endmodule

>>> src/gpa_ctrl.sv
// Controller: steps through the operation program one operation at a time
// and runs the input and result handshakes. Depends on gpa_pkg.
module gpa_ctrl import gpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output cmd_t    cmd,
  input  status_t status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_load;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    can_load      = !out_valid_r || out_tready;
    cmd.load_in   = 1'b0;
    cmd.issue     = 1'b0;
    cmd.op        = prog_step(step_r);
    cmd.load_out  = 1'b0;
    in_tready     = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          step_nxt    = '0;
          state_nxt   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.op_done) begin
          if (step_r == LAST_STEP) begin
            state_nxt = ST_OUT;
          end else begin
            step_nxt  = step_r + 5'd1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (can_load) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // The result register is full once loaded and empty once taken.
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> src/gravity_pair_accel_accumulator_unit.sv
// Gravitational pair acceleration accumulator. Each request carries a target
// and a source position and the source mass as binary64 values; the block adds
// -(mass / |d|^3) * d into three running binary64 accumulators, using an
// approximate inverse square root (bit-level guess plus one Newton step), and
// returns the accumulators. A request with in_tuser set clears them first.
// All arithmetic rounds to nearest even and keeps subnormals; a NaN sum is
// stored as 0x7ff8000000000000. One request runs 23 dependent operations one
// after another through a shared 6-stage adder and a shared 9-stage
// multiplier: 9 adds, 13 multiplies and one guess. A new request is taken
// only once the previous one has finished, in the cycle after its result is
// loaded into the output register. The result register lets a new request
// start while the previous result waits.
module gravity_pair_accel_accumulator_unit import gpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // target_x, target_y, target_z, source_x, source_y, source_z, source_mass
  input  logic [InDataW-1:0]  in_tdata,
  // clear_accum
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // accel_x, accel_y, accel_z
  output logic [OutDataW-1:0] out_tdata
);

  cmd_t    cmd;
  status_t status;

  gpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  gpa_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .out_data (out_tdata)
  );

endmodule
